[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Each check is sampled on clk and is off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

[rtl/ibs_pkg.sv]
package ibs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 64;
  localparam int LEN_W   = 32;
  localparam int FOUND_W = 10;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  // Write request into the range table
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } ibs_wr_t;

  // Read data from the range table
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } ibs_entry_t;

endpackage

[rtl/interval_binary_search.sv]
// Interval lookup table with a binary search over stored address ranges.
// Request channel (req_valid/req_ready) carries kind, range_start,
// range_length and query_address. kind clear empties the table, kind append
// stores one range (dropped when the table is full), kind query searches.
// Only a query produces a response on rsp_valid/rsp_ready: found and
// found_index (zero when not found).
// Clear and append finish on their transfer. A query runs one probe per
// halving step (table read, 64-bit subtract, compare and narrow), and a
// done state then loads the response register. A query makes at most
// ceil(log2(entries + 1)) probes; the single table read port sets the pace.
// req_ready is high only while no query is in flight; a response waiting in
// the output register does not block clear, append or the next query, but a
// second finished query waits until the receiver takes the first.
// Reset empties the table and drops any pending response; stored entries
// are not cleared and are never read before being written.
`include "assert_macros.svh"

module interval_binary_search import ibs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [KIND_W-1:0] kind,
  input  logic [ADDR_W-1:0] range_start,
  input  logic [LEN_W-1:0]  range_length,
  input  logic [ADDR_W-1:0] query_address,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic              found,
  output logic [FOUND_W-1:0] found_index
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PROBE  = 3'd1;
  localparam logic [2:0] ST_SUB    = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]         state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   low, low_next;
  logic [CNT_W-1:0]   high, high_next;
  logic [ADDR_W-1:0]  q_addr, q_addr_next;
  logic [ADDR_W-1:0]  diff, diff_next;
  logic               below, below_next;
  logic [LEN_W-1:0]   len_r, len_r_next;
  logic               hit, hit_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic               rsp_valid_next;
  logic               found_next;
  logic [FOUND_W-1:0] found_index_next;

  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid;
  logic [ADDR_W:0]    sub;
  logic               holds;
  logic               req_xfer;
  ibs_wr_t            wr;
  logic               rd_en;
  ibs_entry_t         rd_data;

  ibs_table u_table (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (mid[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Midpoint of the half-open interval, stable from probe to decide
  assign mid_sum = {1'b0, low} + {1'b0, high};
  assign mid     = mid_sum[CNT_W:1];

  // Offset of the query from the probed start; borrow means query is below it
  assign sub   = {1'b0, q_addr} - {1'b0, rd_data.start};
  assign holds = (diff[ADDR_W-1:LEN_W] == '0) && (diff[LEN_W-1:0] < len_r);

  assign req_ready = (state == ST_IDLE);
  assign req_xfer  = req_valid && req_ready;

  // Table write on an append transfer with room left
  always_comb begin
    wr.en    = req_xfer && (kind == KIND_APPEND) && (count < CNT_W'(TABLE_DEPTH));
    wr.addr  = count[IDX_W-1:0];
    wr.start = range_start;
    wr.len   = range_length;
  end

  // Sequencer
  always_comb begin
    state_next       = state;
    count_next       = count;
    low_next         = low;
    high_next        = high;
    q_addr_next      = q_addr;
    diff_next        = diff;
    below_next       = below;
    len_r_next       = len_r;
    hit_next         = hit;
    idx_next         = idx;
    rsp_valid_next   = rsp_valid && !rsp_ready;
    found_next       = found;
    found_index_next = found_index;
    rd_en            = 1'b0;

    case (state)
      ST_IDLE: begin
        if (req_xfer) begin
          case (kind)
            KIND_CLEAR: begin
              count_next = '0;
            end
            KIND_APPEND: begin
              if (wr.en) begin
                count_next = count + CNT_W'(1);
              end
            end
            KIND_QUERY: begin
              q_addr_next = query_address;
              low_next    = '0;
              high_next   = count;
              state_next  = ST_PROBE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PROBE: begin
        if (low < high) begin
          rd_en      = 1'b1;
          state_next = ST_SUB;
        end else begin
          hit_next   = 1'b0;
          idx_next   = '0;
          state_next = ST_DONE;
        end
      end
      ST_SUB: begin
        diff_next  = sub[ADDR_W-1:0];
        below_next = sub[ADDR_W];
        len_r_next = rd_data.len;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (below) begin
          high_next  = mid;
          state_next = ST_PROBE;
        end else if (!holds) begin
          low_next   = mid + CNT_W'(1);
          state_next = ST_PROBE;
        end else begin
          hit_next   = 1'b1;
          idx_next   = mid[IDX_W-1:0];
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // Load the response once the output register is free
        if (!rsp_valid || rsp_ready) begin
          rsp_valid_next   = 1'b1;
          found_next       = hit;
          found_index_next = FOUND_W'(idx);
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // Search and response payload
  always_ff @(posedge clk) begin
    low         <= low_next;
    high        <= high_next;
    q_addr      <= q_addr_next;
    diff        <= diff_next;
    below       <= below_next;
    len_r       <= len_r_next;
    hit         <= hit_next;
    idx         <= idx_next;
    found       <= found_next;
    found_index <= found_index_next;
  end

  `ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(TABLE_DEPTH), "entry count exceeds table depth")
  `ASSERT_ALWAYS(a_probe_in_table, (state == ST_PROBE && low < high) |-> (mid < count), "probe outside written entries")
  `ASSERT_ALWAYS(a_interval_order, (state == ST_SUB || state == ST_DECIDE) |-> (low < high), "search interval collapsed during probe")
  `ASSERT_ALWAYS(a_miss_index_zero, (rsp_valid && !found) |-> (found_index == '0), "nonzero index on a miss")
  `ASSERT_NEXT(a_rsp_from_done, !rsp_valid && state != ST_DONE, !rsp_valid, "response raised without a finished query")

endmodule

[rtl/ibs_table.sv]
module ibs_table import ibs_pkg::*; (
  input  logic             clk,
  input  ibs_wr_t          wr,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output ibs_entry_t       rd_data
);

  ibs_entry_t mem [TABLE_DEPTH];

  // Write one entry per transfer
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= '{start: wr.start, len: wr.len};
    end
  end

  // Registered read, held until the next probe
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
